[hw/rtl/fdw_pkg.sv]
package fdw_pkg;

    // Field store geometry
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELL_BITS  = 16;

    localparam int X_W    = $clog2(MAX_WIDTH);
    localparam int Y_W    = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = X_W + Y_W;

    // Register and field widths
    localparam int SIZE_W  = 7;
    localparam int STR_W   = 16;
    localparam int PH_W    = 3;
    localparam int VALUE_W = 16;
    localparam int IDX_W   = 3;
    localparam int DATA_W  = 16;

    // step = warp_strength / 125 as a reciprocal multiply, exact for 16-bit inputs
    localparam int STEP_DIV   = 125;
    localparam int STEP_SHIFT = 23;
    localparam int RECIP_W    = 17;
    localparam logic [RECIP_W-1:0] STEP_RECIP = RECIP_W'(((1 << STEP_SHIFT) / STEP_DIV) + 1);
    localparam int STEP_MAX   = ((1 << STR_W) - 1) / STEP_DIV;
    localparam int STEP_W     = $clog2(STEP_MAX + 1);
    localparam int PROD_W     = STR_W + RECIP_W;

    // Largest coordinate before the modulo: coordinate plus 7 * step
    localparam int DVD_MAX = ((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) - 1
                             + ((1 << PH_W) - 1) * STEP_MAX;
    localparam int DVD_W   = $clog2(DVD_MAX + 1);
    localparam int CNT_W   = $clog2(DVD_W);

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_FIELD_WIDTH   = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_FIELD_HEIGHT  = IDX_W'(1);
    localparam logic [IDX_W-1:0] CFG_WARP_STRENGTH = IDX_W'(2);
    localparam logic [IDX_W-1:0] CFG_PHASE_X       = IDX_W'(3);
    localparam logic [IDX_W-1:0] CFG_PHASE_Y       = IDX_W'(4);

    // Request and status codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_WARP   = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [SIZE_W-1:0] rem;
    } remu_sts_t;

endpackage

[hw/rtl/field_domain_warp.sv]
// Domain-warp lookup over a 64 x 64 field store.
// Input channel s_*: one transaction per request. A load (req_type 0) writes
// cell_value at (cell_x, cell_y) when inside the field and gives no result. A warp
// (req_type 1) reads the cell, offsets both coordinates by the phased low
// bits of that value times warp_strength / 125, wraps them by the field size
// and returns the value at the source cell on m_*. A warp performs
// two store reads, one reciprocal multiply, and two remainders of 12 bit
// steps each on a single shared bit-serial remainder unit. A warp addressed
// outside the field, or whose wrapped source lies past the store, answers
// status bad_size with value 0.
// s_ready is high only while the sequencer is idle; one request at a time.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_wdata, always ready;
// write only while no request is in flight.
// Reset (aresetn low, synchronous) restores the register defaults and empties
// the result register; store contents stay undefined until loaded.
// If m_ready is low, the result waits in the output register; a new request
// is still accepted, and the sequencer holds its next result until the
// output register is free.
module field_domain_warp (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdw_pkg::IDX_W-1:0]     cfg_index,
    input  logic [fdw_pkg::DATA_W-1:0]    cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_req_type,
    input  logic [fdw_pkg::X_W-1:0]       s_cell_x,
    input  logic [fdw_pkg::Y_W-1:0]       s_cell_y,
    input  logic [fdw_pkg::VALUE_W-1:0]   s_cell_value,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fdw_pkg::VALUE_W-1:0]   m_warped_value,
    output logic                          m_status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_OFFX = 3'd2;
    localparam logic [2:0] S_MODX = 3'd3;
    localparam logic [2:0] S_MODY = 3'd4;
    localparam logic [2:0] S_RD2  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;

    // Configuration
    logic [fdw_pkg::SIZE_W-1:0] fwidth_reg;
    logic [fdw_pkg::SIZE_W-1:0] fheight_reg;
    logic [fdw_pkg::STR_W-1:0]  strength_reg;
    logic [fdw_pkg::PH_W-1:0]   phx_reg;
    logic [fdw_pkg::PH_W-1:0]   phy_reg;

    // Request context
    logic [fdw_pkg::X_W-1:0]    x_reg, x_next;
    logic [fdw_pkg::Y_W-1:0]    y_reg, y_next;
    logic [fdw_pkg::PH_W-1:0]   tx_reg, tx_next;
    logic [fdw_pkg::PH_W-1:0]   ty_reg, ty_next;
    logic [fdw_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [fdw_pkg::SIZE_W-1:0] sx_reg, sx_next;
    logic [fdw_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic                       res_status_reg, res_status_next;

    // Output register
    logic                        m_valid_reg, m_valid_next;
    logic [fdw_pkg::VALUE_W-1:0] m_value_reg, m_value_next;
    logic                        m_status_reg, m_status_next;

    logic                          accept;
    logic                          in_field;
    logic [fdw_pkg::STEP_W-1:0]    step;
    logic [fdw_pkg::DVD_W-1:0]     dvd_x;
    logic [fdw_pkg::DVD_W-1:0]     dvd_y;
    logic                          remu_start;
    logic [fdw_pkg::DVD_W-1:0]     remu_dividend;
    logic [fdw_pkg::SIZE_W-1:0]    remu_divisor;
    fdw_pkg::remu_sts_t            remu_sts;
    logic                          mem_we;
    logic                          mem_re;
    logic [fdw_pkg::ADDR_W-1:0]    mem_addr;
    logic [fdw_pkg::CELL_BITS-1:0] mem_rdata;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwidth_reg   <= fdw_pkg::SIZE_W'(fdw_pkg::MAX_WIDTH);
            fheight_reg  <= fdw_pkg::SIZE_W'(fdw_pkg::MAX_HEIGHT);
            strength_reg <= '0;
            phx_reg      <= '0;
            phy_reg      <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                fdw_pkg::CFG_FIELD_WIDTH:   fwidth_reg   <= cfg_wdata[fdw_pkg::SIZE_W-1:0];
                fdw_pkg::CFG_FIELD_HEIGHT:  fheight_reg  <= cfg_wdata[fdw_pkg::SIZE_W-1:0];
                fdw_pkg::CFG_WARP_STRENGTH: strength_reg <= cfg_wdata[fdw_pkg::STR_W-1:0];
                fdw_pkg::CFG_PHASE_X:       phx_reg      <= cfg_wdata[fdw_pkg::PH_W-1:0];
                fdw_pkg::CFG_PHASE_Y:       phy_reg      <= cfg_wdata[fdw_pkg::PH_W-1:0];
                default: ;
            endcase
        end
    end

    // A zero width or height fails its compare, so it is covered here too
    assign in_field = ({1'b0, s_cell_x} < fwidth_reg) && ({1'b0, s_cell_y} < fheight_reg);

    assign step  = prod_reg[fdw_pkg::STEP_SHIFT +: fdw_pkg::STEP_W];
    assign dvd_x = fdw_pkg::DVD_W'(x_reg) + fdw_pkg::DVD_W'(tx_reg * step);
    assign dvd_y = fdw_pkg::DVD_W'(y_reg) + fdw_pkg::DVD_W'(ty_reg * step);

    always_comb begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        prod_next       = prod_reg;
        sx_next         = sx_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        remu_start      = 1'b0;
        remu_dividend   = dvd_x;
        remu_divisor    = fwidth_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = {s_cell_y, s_cell_x};

        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    x_next = s_cell_x;
                    y_next = s_cell_y;
                    if (s_req_type == fdw_pkg::REQ_LOAD) begin
                        mem_we = in_field;
                    end else if (in_field) begin
                        mem_re     = 1'b1;
                        state_next = S_MUL;
                    end else begin
                        res_value_next  = '0;
                        res_status_next = fdw_pkg::STATUS_BAD;
                        state_next      = S_OUT;
                    end
                end
            end
            S_MUL: begin
                tx_next    = mem_rdata[fdw_pkg::PH_W-1:0] + phx_reg;
                ty_next    = mem_rdata[fdw_pkg::PH_W-1:0] + phy_reg;
                prod_next  = fdw_pkg::PROD_W'(strength_reg * fdw_pkg::STEP_RECIP);
                state_next = S_OFFX;
            end
            S_OFFX: begin
                remu_start = 1'b1;
                state_next = S_MODX;
            end
            S_MODX: begin
                if (remu_sts.done) begin
                    sx_next       = remu_sts.rem;
                    remu_start    = 1'b1;
                    remu_dividend = dvd_y;
                    remu_divisor  = fheight_reg;
                    state_next    = S_MODY;
                end
            end
            S_MODY: begin
                if (remu_sts.done) begin
                    // Configured size above the store can wrap to a source past its edge
                    if (sx_reg >= fdw_pkg::SIZE_W'(fdw_pkg::MAX_WIDTH) ||
                        remu_sts.rem >= fdw_pkg::SIZE_W'(fdw_pkg::MAX_HEIGHT)) begin
                        res_value_next  = '0;
                        res_status_next = fdw_pkg::STATUS_BAD;
                        state_next      = S_OUT;
                    end else begin
                        mem_re     = 1'b1;
                        mem_addr   = {remu_sts.rem[fdw_pkg::Y_W-1:0],
                                      sx_reg[fdw_pkg::X_W-1:0]};
                        state_next = S_RD2;
                    end
                end
            end
            S_RD2: begin
                res_value_next  = fdw_pkg::VALUE_W'(mem_rdata);
                res_status_next = fdw_pkg::STATUS_OK;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        tx_reg         <= tx_next;
        ty_reg         <= ty_next;
        prod_reg       <= prod_next;
        sx_reg         <= sx_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
    end

    fdw_store u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (fdw_pkg::CELL_BITS'(s_cell_value)),
        .rdata (mem_rdata)
    );

    fdw_remu u_remu (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (remu_start),
        .dividend (remu_dividend),
        .divisor  (remu_divisor),
        .sts      (remu_sts)
    );

    assign m_valid        = m_valid_reg;
    assign m_warped_value = m_value_reg;
    assign m_status       = m_status_reg;

    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == fdw_pkg::STATUS_BAD) |-> (m_warped_value == '0))
        else $error("bad_size result carries a nonzero value");

    a_remu_free: assert property (@(posedge aclk) disable iff (!aresetn)
        remu_start |-> !remu_sts.busy)
        else $error("remainder unit restarted while busy");

    a_warp_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && (s_req_type == fdw_pkg::REQ_WARP) |=> !s_ready)
        else $error("ready after accepting a warp request");

    a_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> accept && (s_req_type == fdw_pkg::REQ_LOAD))
        else $error("store write outside a load transaction");

endmodule

[hw/rtl/fdw_store.sv]
module fdw_store (
    input  logic                          aclk,
    input  logic                          we,
    input  logic                          re,
    input  logic [fdw_pkg::ADDR_W-1:0]    addr,
    input  logic [fdw_pkg::CELL_BITS-1:0] wdata,
    output logic [fdw_pkg::CELL_BITS-1:0] rdata
);

    logic [fdw_pkg::CELL_BITS-1:0] mem [(1 << fdw_pkg::ADDR_W)];
    logic [fdw_pkg::CELL_BITS-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fdw_remu.sv]
// Restoring remainder, one dividend bit per cycle.
module fdw_remu (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [fdw_pkg::DVD_W-1:0]  dividend,
    input  logic [fdw_pkg::SIZE_W-1:0] divisor,
    output fdw_pkg::remu_sts_t         sts
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [fdw_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [fdw_pkg::DVD_W-1:0]  dvd_reg, dvd_next;
    logic [fdw_pkg::SIZE_W-1:0] dsr_reg, dsr_next;
    logic [fdw_pkg::SIZE_W-1:0] rem_reg, rem_next;
    logic [fdw_pkg::SIZE_W:0]   trial;

    assign trial = {rem_reg, dvd_reg[fdw_pkg::DVD_W-1]};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = fdw_pkg::SIZE_W'(trial - {1'b0, dsr_reg});
            end else begin
                rem_next = fdw_pkg::SIZE_W'(trial);
            end
            dvd_next = {dvd_reg[fdw_pkg::DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == fdw_pkg::CNT_W'(fdw_pkg::DVD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign sts.rem  = rem_reg;

endmodule

[test/fdw_warp_checker.sv]
`timescale 1ns / 100ps

module fdw_warp_checker
    import fdw_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [DATA_W-1:0]   cfg_wdata,

    input  logic                s_valid,
    input  logic                s_ready,
    input  logic                s_req_type,
    input  logic [X_W-1:0]      s_cell_x,
    input  logic [Y_W-1:0]      s_cell_y,
    input  logic [VALUE_W-1:0]  s_cell_value,

    input  logic                m_valid,
    input  logic                m_ready,
    input  logic [VALUE_W-1:0]  m_warped_value,
    input  logic                m_status,

    output int                  fail_count,
    output int                  pending,
    output int                  warps_seen,
    output int                  bad_seen
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               status;
    } warp_result_t;

    logic [CELL_BITS-1:0] field_cells [MAX_WIDTH*MAX_HEIGHT];
    logic [SIZE_W-1:0]    width_r;
    logic [SIZE_W-1:0]    height_r;
    logic [STR_W-1:0]     strength_r;
    logic [PH_W-1:0]      phx_r;
    logic [PH_W-1:0]      phy_r;
    warp_result_t         expected_warps [$];
    warp_result_t         want;

    initial begin
        fail_count = 0;
        pending    = 0;
        warps_seen = 0;
        bad_seen   = 0;
    end

    function automatic bit in_field(logic [X_W-1:0] x, logic [Y_W-1:0] y);
        return x < width_r && y < height_r && x < MAX_WIDTH && y < MAX_HEIGHT;
    endfunction

    function automatic warp_result_t warp_lookup(logic [X_W-1:0] x, logic [Y_W-1:0] y);
        warp_result_t r;
        int unsigned  v;
        int unsigned  step;
        int unsigned  sx;
        int unsigned  sy;
        r.value  = '0;
        r.status = STATUS_BAD;
        if (!in_field(x, y))
            return r;
        v    = field_cells[y * MAX_WIDTH + x];
        step = strength_r / STEP_DIV;
        sx   = (x + ((v + phx_r) & ((1 << PH_W) - 1)) * step) % width_r;
        sy   = (y + ((v + phy_r) & ((1 << PH_W) - 1)) * step) % height_r;
        // wrapped source can land past the store when the size exceeds it
        if (sx >= MAX_WIDTH || sy >= MAX_HEIGHT)
            return r;
        r.value  = field_cells[sy * MAX_WIDTH + sx][VALUE_W-1:0];
        r.status = STATUS_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        fail_count++;
        if (fail_count <= 100)
            $display("ERROR @%0t result %0d: %s", $realtime, warps_seen, what);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_r    = SIZE_W'(MAX_WIDTH);
            height_r   = SIZE_W'(MAX_HEIGHT);
            strength_r = '0;
            phx_r      = '0;
            phy_r      = '0;
            expected_warps.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIELD_WIDTH:   width_r    = cfg_wdata[SIZE_W-1:0];
                    CFG_FIELD_HEIGHT:  height_r   = cfg_wdata[SIZE_W-1:0];
                    CFG_WARP_STRENGTH: strength_r = cfg_wdata[STR_W-1:0];
                    CFG_PHASE_X:       phx_r      = cfg_wdata[PH_W-1:0];
                    CFG_PHASE_Y:       phy_r      = cfg_wdata[PH_W-1:0];
                    default: ;
                endcase
            end
            // results first, so a request taken in this cycle cannot match
            if (m_valid && m_ready) begin
                warps_seen++;
                if (expected_warps.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction value %h status %b",
                                              m_warped_value, m_status));
                end else begin
                    want = expected_warps.pop_front();
                    if (want.status == STATUS_BAD)
                        bad_seen++;
                    if (m_warped_value !== want.value)
                        report_mismatch($sformatf("warped_value %h, expected %h",
                                                  m_warped_value, want.value));
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %b, expected %b",
                                                  m_status, want.status));
                end
            end
            if (s_valid && s_ready) begin
                if (s_req_type == REQ_LOAD) begin
                    if (in_field(s_cell_x, s_cell_y))
                        field_cells[s_cell_y * MAX_WIDTH + s_cell_x] = s_cell_value;
                end else begin
                    expected_warps.push_back(warp_lookup(s_cell_x, s_cell_y));
                end
            end
        end
        pending = expected_warps.size();
    end

endmodule

[test/field_domain_warp_tb.sv]
`timescale 1ns / 100ps

module field_domain_warp_tb;
    import fdw_pkg::*;

    localparam int RUN_LIMIT     = 500_000;
    localparam int TARGET_ITEMS  = 450;
    localparam int SETTLE_CYCLES = 48;

    typedef enum int {RX_OPEN, RX_COIN, RX_BLOCKS} rx_mode_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_index      = '0;
    logic [DATA_W-1:0]   cfg_wdata      = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_req_type     = REQ_LOAD;
    logic [X_W-1:0]      s_cell_x       = '0;
    logic [Y_W-1:0]      s_cell_y       = '0;
    logic [VALUE_W-1:0]  s_cell_value   = '0;
    logic                m_valid;
    logic                m_ready        = 1'b1;
    logic [VALUE_W-1:0]  m_warped_value;
    logic                m_status;

    int fail_count;
    int pending;
    int warps_seen;
    int bad_seen;

    // cells loaded so far; every in-field cell is loaded before random warps
    bit       cell_loaded [MAX_WIDTH*MAX_HEIGHT];
    int       cur_w         = MAX_WIDTH;
    int       cur_h         = MAX_HEIGHT;
    int       items_done    = 0;
    int       loads_done    = 0;
    int       phases_done   = 0;
    int       burst_left    = 0;
    bit       req_effective;
    int       cycles        = 0;
    rx_mode_t rx_mode       = RX_OPEN;
    int       rx_left       = 0;
    int       rx_hold       = 0;
    bit       rx_level      = 1'b1;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    field_domain_warp uut (.*);

    fdw_warp_checker u_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("field_domain_warp test failed");
            $finish;
        end
    end

    // result side: open stretches, coin-flip stalls, and long blocks
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_left = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN: m_ready <= 1'b1;
            RX_COIN: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold == 0) begin
                    rx_level = !rx_level;
                    rx_hold  = rx_level ? $urandom_range(1, 4) : $urandom_range(1, 24);
                end
                rx_hold--;
                m_ready <= rx_level;
            end
        endcase
    end

    task automatic send_req(logic req, int x, int y, int value);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_cell_x     <= X_W'(x);
        s_cell_y     <= Y_W'(y);
        s_cell_value <= VALUE_W'(value);
        do @(posedge aclk); while (!s_ready);
        req_effective = (req == REQ_WARP) || (x < cur_w && y < cur_h);
        if (req_effective)
            items_done++;
        if (req == REQ_LOAD && req_effective) begin
            cell_loaded[y * MAX_WIDTH + x] = 1'b1;
            loads_done++;
        end
    endtask

    // drop valid, drain results, then let a trailing load or warp finish
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, int unsigned data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= DATA_W'(data);
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic set_config(int w, int h, int strength, int px, int py);
        settle();
        write_reg(CFG_FIELD_WIDTH, w);
        write_reg(CFG_FIELD_HEIGHT, h);
        write_reg(CFG_WARP_STRENGTH, strength);
        write_reg(CFG_PHASE_X, px);
        write_reg(CFG_PHASE_Y, py);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cur_w = w;
        cur_h = h;
        phases_done++;
    endtask

    initial begin
        int                 p;
        int                 fx;
        int                 fy;
        int                 random_items;
        int                 strength;
        logic               req;
        int                 x;
        int                 y;
        int                 value;

        p = 0;
        random_items = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting has step 0, so a warp reads only its own cell
        send_req(REQ_LOAD, 0, 0, 16'h0000);
        send_req(REQ_LOAD, 63, 63, 16'hFFFF);
        send_req(REQ_LOAD, 63, 0, 16'hAAAA);
        send_req(REQ_LOAD, 0, 63, 16'h5555);
        send_req(REQ_WARP, 0, 0, 16'hFFFF);
        send_req(REQ_WARP, 63, 63, 16'h0000);
        send_req(REQ_WARP, 63, 0, 16'h0000);
        send_req(REQ_WARP, 0, 63, 16'h0000);
        send_req(REQ_LOAD, 63, 63, 16'h1234);
        send_req(REQ_WARP, 63, 63, 16'h0000);

        // zero width or height: everything is outside the field
        set_config(0, 64, 0, 0, 0);
        send_req(REQ_WARP, 0, 0, 16'h0000);
        send_req(REQ_LOAD, 5, 5, 16'hBEEF);
        send_req(REQ_WARP, 63, 63, 16'h0000);
        set_config(64, 0, 0, 0, 0);
        send_req(REQ_WARP, 63, 0, 16'h0000);

        // step 64 on a 64 x 64 field wraps back onto the same cell
        set_config(64, 64, 8000, 7, 5);
        send_req(REQ_WARP, 0, 0, 16'h0000);
        send_req(REQ_WARP, 63, 63, 16'h0000);
        send_req(REQ_WARP, 0, 63, 16'h0000);
        send_req(REQ_WARP, 63, 0, 16'h0000);

        // width past the store: source column 67 is out of the store
        set_config(127, 64, 125, 0, 0);
        send_req(REQ_WARP, 63, 63, 16'h0000);
        send_req(REQ_WARP, 0, 0, 16'h0000);

        while (p < 6 || items_done < TARGET_ITEMS) begin
            case ($urandom_range(0, 4))
                0:       strength = 0;
                1:       strength = 124;
                2:       strength = 125;
                3:       strength = 65535;
                default: strength = $urandom_range(0, 65535);
            endcase
            case (p)
                0: set_config(64, 1, 65535, 7, 7);
                1: set_config(1, 64, 125, 0, 3);
                2: set_config(127, 2, strength, $urandom_range(0, 7), $urandom_range(0, 7));
                3: set_config(0, 5, strength, 7, 0);
                4: set_config(5, 0, strength, 0, 7);
                5: set_config(2, 127, 65535, $urandom_range(0, 7), $urandom_range(0, 7));
                default: begin
                    if ($urandom_range(0, 5) == 0)
                        set_config($urandom_range(65, 127), $urandom_range(1, 2), strength,
                                   $urandom_range(0, 7), $urandom_range(0, 7));
                    else
                        set_config($urandom_range(1, 12), $urandom_range(1, 12), strength,
                                   $urandom_range(0, 7), $urandom_range(0, 7));
                end
            endcase
            fx = (cur_w < MAX_WIDTH) ? cur_w : MAX_WIDTH;
            fy = (cur_h < MAX_HEIGHT) ? cur_h : MAX_HEIGHT;

            for (int yy = 0; yy < fy; yy++)
                for (int xx = 0; xx < fx; xx++)
                    if (!cell_loaded[yy * MAX_WIDTH + xx])
                        send_req(REQ_LOAD, xx, yy, $urandom_range(0, 65535));

            repeat ($urandom_range(20, 40)) begin
                req = ($urandom_range(0, 99) < 30) ? REQ_LOAD : REQ_WARP;
                if (fx > 0 && fy > 0 && $urandom_range(0, 99) < 85) begin
                    x = $urandom_range(0, fx - 1);
                    y = $urandom_range(0, fy - 1);
                end else begin
                    x = $urandom_range(0, MAX_WIDTH - 1);
                    y = $urandom_range(0, MAX_HEIGHT - 1);
                end
                case ($urandom_range(0, 7))
                    0:       value = 0;
                    1:       value = 65535;
                    default: value = $urandom_range(0, 65535);
                endcase
                send_req(req, x, y, value);
                if (req_effective)
                    random_items++;
            end
            p++;
        end

        settle();
        $display("Covered %0d requests (%0d stored loads, %0d random) over %0d register settings",
                 items_done, loads_done, random_items, phases_done);
        $display("Checked %0d warp results, %0d of them bad_size", warps_seen, bad_seen);
        if (fail_count == 0 && pending == 0)
            $display("field_domain_warp test passed");
        else
            $display("field_domain_warp test failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/fdw_pkg.sv
hw/rtl/fdw_store.sv
hw/rtl/fdw_remu.sv
hw/rtl/field_domain_warp.sv
test/fdw_warp_checker.sv
test/field_domain_warp_tb.sv
